// ===== design/refcounted_page_allocator_assert.svh =====
// Assertion macros used by the assertion checker of the page allocator.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define RPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define RPA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle consequence of reset itself.
`define RPA_ASSERT_RST(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rpa_pkg.sv =====
package rpa_pkg;

   // Defaults of the top-level parameters.
   localparam int NUM_PAGES_DEFAULT  = 65536;
   localparam int PAGE_SHIFT_DEFAULT = 12;
   localparam int COUNT_BITS_DEFAULT = 8;

   // Fixed field widths of the streams and registers.
   localparam int OP_W     = 2;
   localparam int ADDR_W   = 28;
   localparam int STATUS_W = 2;
   localparam int REF_W    = 8;
   localparam int REG_W    = 29;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 40;
   localparam int RSP_USED = STATUS_W + ADDR_W + REF_W + 1;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [REG_W-1:0] LOW_ADDR_RESET = '0;
   localparam logic [REG_W-1:0] TOP_ADDR_RESET = REG_W'(29'h1000_0000);

   // Register indexes (paddr bit 2).
   localparam logic REG_LOW_ADDR = 1'b0;
   localparam logic REG_TOP_ADDR = 1'b1;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_ADDREF = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVF = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic slot_free;
   } dp_status_type;

endpackage

// ===== design/rpa_ram.sv =====
module rpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rpa_ctrl.sv =====
module rpa_ctrl import rpa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (dp_status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (dp_status.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready     = (state_ff == S_IDLE);
   assign cmd.clear_step = (state_ff == S_CLEAR);
   assign cmd.accept     = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.commit     = (state_ff == S_EXEC) && dp_status.slot_free;

endmodule

// ===== design/rpa_datapath.sv =====
module rpa_datapath import rpa_pkg::*; #(
   parameter int NUM_PAGES  = NUM_PAGES_DEFAULT,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     dp_status,
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic [REG_W-1:0]  low_addr,
   input  logic [REG_W-1:0]  top_addr,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata
);

   localparam int IDX_W   = $clog2(NUM_PAGES);
   localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
   localparam int PG_W    = ADDR_W - PAGE_SHIFT;

   // Item registers.
   logic [OP_W-1:0]   op_ff;
   logic [ADDR_W-1:0] pa_ff;

   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] depth_in;
   logic [IDX_W-1:0]   clr_cnt_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_page_ff;
   logic [REF_W-1:0]    rsp_ref_ff;
   logic                rsp_rel_ff;

   // Memory ports.
   logic                  cnt_we;
   logic [IDX_W-1:0]      cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic [COUNT_BITS-1:0] cnt_rd;
   logic                  stk_we;
   logic [IDX_W-1:0]      stk_rd;

   // Per-item decode.
   logic [PG_W-1:0]       in_pg;
   logic [PG_W-1:0]       pg;
   logic [IDX_W-1:0]      idx;
   logic                  pg_bad;
   logic                  free_bad;
   logic                  stack_full;
   logic [COUNT_BITS-1:0] cnt_dec;
   logic [COUNT_BITS-1:0] cnt_inc;

   // Result of the item in flight.
   logic [STATUS_W-1:0]   res_status;
   logic [ADDR_W-1:0]     res_page;
   logic [REF_W-1:0]      res_ref;
   logic                  res_rel;
   logic                  res_cnt_we;
   logic [IDX_W-1:0]      res_cnt_idx;
   logic [COUNT_BITS-1:0] res_cnt_val;
   logic                  res_push;

   assign in_pg = req_tdata[OP_W+ADDR_W-1:OP_W+PAGE_SHIFT];
   assign pg    = pa_ff[ADDR_W-1:PAGE_SHIFT];
   assign idx   = IDX_W'(pg);

   assign pg_bad     = 32'(pg) >= 32'(NUM_PAGES);
   assign free_bad   = (|pa_ff[PAGE_SHIFT-1:0]) || ({1'b0, pa_ff} < low_addr) ||
                       ({1'b0, pa_ff} >= top_addr);
   assign stack_full = (depth_ff == DEPTH_W'(NUM_PAGES));
   assign cnt_dec    = (cnt_rd == '0) ? cnt_rd : cnt_rd - 1'b1;
   assign cnt_inc    = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;

   always_comb begin
      res_status  = ST_OK;
      res_page    = '0;
      res_ref     = REF_W'(cnt_rd);
      res_rel     = 1'b0;
      res_cnt_we  = 1'b0;
      res_cnt_idx = idx;
      res_cnt_val = cnt_rd;
      res_push    = 1'b0;
      depth_in    = depth_ff;
      if (op_ff == OP_ALLOC) begin
         if (depth_ff == '0) begin
            res_status = ST_OOM;
            res_ref    = '0;
         end else begin
            depth_in    = depth_ff - 1'b1;
            res_page    = ADDR_W'({stk_rd, {PAGE_SHIFT{1'b0}}});
            res_ref     = REF_W'(1);
            res_cnt_we  = 1'b1;
            res_cnt_idx = stk_rd;
            res_cnt_val = COUNT_BITS'(1);
         end
      end else if (pg_bad) begin
         res_status = ST_BAD;
         res_ref    = '0;
      end else begin
         case (op_ff)
            OP_FREE: begin
               if (free_bad) begin
                  res_status = ST_BAD;
                  res_ref    = '0;
               end else begin
                  res_cnt_we  = 1'b1;
                  res_cnt_val = cnt_dec;
                  res_ref     = REF_W'(cnt_dec);
                  if (cnt_dec == '0) begin
                     if (stack_full) begin
                        res_status = ST_OVF;
                     end else begin
                        res_push = 1'b1;
                        res_rel  = 1'b1;
                        depth_in = depth_ff + 1'b1;
                     end
                  end
               end
            end
            OP_ADDREF: begin
               res_cnt_we  = 1'b1;
               res_cnt_val = cnt_inc;
               res_ref     = REF_W'(cnt_inc);
            end
            default: begin
            end
         endcase
      end
   end

   // The clearing pass owns the count write port until it finishes.
   assign cnt_we    = cmd.clear_step || (cmd.commit && res_cnt_we);
   assign cnt_waddr = cmd.clear_step ? clr_cnt_ff : res_cnt_idx;
   assign cnt_wdata = cmd.clear_step ? '0 : res_cnt_val;
   assign stk_we    = cmd.commit && res_push;

   rpa_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_PAGES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (IDX_W'(in_pg)),
      .rd_data (cnt_rd)
   );

   rpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_PAGES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (IDX_W'(depth_ff)),
      .wr_data (idx),
      .rd_en   (cmd.accept),
      .rd_addr (IDX_W'(depth_ff - 1'b1)),
      .rd_data (stk_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.commit) begin
            depth_ff     <= depth_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff <= req_tdata[OP_W-1:0];
         pa_ff <= req_tdata[OP_W+ADDR_W-1:OP_W];
      end
      if (cmd.commit) begin
         rsp_status_ff <= res_status;
         rsp_page_ff   <= res_page;
         rsp_ref_ff    <= res_ref;
         rsp_rel_ff    <= res_rel;
      end
   end

   assign dp_status.clear_last = (clr_cnt_ff == IDX_W'(NUM_PAGES - 1));
   assign dp_status.slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - RSP_USED){1'b0}}, rsp_rel_ff, rsp_ref_ff,
                        rsp_page_ff, rsp_status_ff};

endmodule

// ===== design/refcounted_page_allocator.sv =====
// Page allocator with a last-in first-out free stack and a reference count per page.
// Requests arrive on the req_ stream, one transfer per operation (allocate, free,
// add reference, query); each request gives exactly one result transfer on rsp_.
// low_addr and top_addr must be written through the csr_ port while the block is idle;
// the block itself does not enforce this. A request is taken in the idle state and the
// count and stack memories are read at that edge; in the execute state the result is
// computed and, once the output register is free, registered for rsp_ together with
// the memory updates. A new request is taken only after the result of the last one
// is registered, since the registered read port of the count memory must return the
// entry before its update is written back.
// After reset the count memory is swept to zero, one entry per cycle; req_tready stays
// low during that pass while csr_ writes are still taken. The free stack starts empty,
// so software frees every usable page once before allocating.
// If the receiver stalls, the result waits in the output register and one more
// request is still taken; its result is held back, with no memory updated, until
// the output register is free again.
module refcounted_page_allocator import rpa_pkg::*; #(
   parameter int NUM_PAGES  = NUM_PAGES_DEFAULT,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [1:0] op, [29:2] phys_addr, [31:30] zero
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [1:0] status, [29:2] page_addr, [37:30] ref_count, [38] page_released, [39] zero
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   logic [REG_W-1:0] low_addr_ff;
   logic [REG_W-1:0] top_addr_ff;
   logic             csr_write;

   // Registers decode on address bit 2 only; the byte offset within a word is ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_addr_ff <= LOW_ADDR_RESET;
         top_addr_ff <= TOP_ADDR_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_TOP_ADDR) begin
            top_addr_ff <= csr_pwdata[REG_W-1:0];
         end else begin
            low_addr_ff <= csr_pwdata[REG_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_LOW_ADDR) ? CSR_DW'(low_addr_ff)
                                                      : CSR_DW'(top_addr_ff);

   // The controller sequences clearing, request intake and commit of each result.
   rpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   // The datapath holds the memories, the stack depth and the output register.
   rpa_datapath #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .req_tdata  (req_tdata),
      .low_addr   (low_addr_ff),
      .top_addr   (top_addr_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== design/rpa_checker.sv =====
`include "refcounted_page_allocator_assert.svh"

module rpa_checker import rpa_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // Only one request is worked on at a time.
   `RPA_ASSERT_NXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while another is in flight")

   // A result offered and not taken stays unchanged.
   `RPA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // Any failure reports no page, no count and no release.
   `RPA_ASSERT_IMP(a_fail_clean, clock, reset, rsp_tvalid && (rsp_tdata[1:0] != ST_OK), rsp_tdata[RSP_W-1:2] == '0, "failed result carries data")

   // A released page means a successful free that left the count at zero.
   `RPA_ASSERT_IMP(a_release_ok, clock, reset, rsp_tvalid && rsp_tdata[38], (rsp_tdata[1:0] == ST_OK) && (rsp_tdata[37:2] == '0), "release with nonzero count or status")

   // Reset empties the output and starts the clearing pass.
   `RPA_ASSERT_RST(a_reset_quiet, clock, reset, !req_tready && !rsp_tvalid, "block active right after reset")

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/page_allocator_checker.sv =====
module page_allocator_checker import rpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   input  logic [CSR_DW-1:0] csr_prdata,
   input  logic              csr_pready,
   output int                failures,
   output int                pending
);

   localparam int PAGES     = NUM_PAGES_DEFAULT;
   localparam int SHIFT     = PAGE_SHIFT_DEFAULT;
   localparam int PAGE_W    = ADDR_W - SHIFT;
   localparam int COUNT_TOP = (1 << COUNT_BITS_DEFAULT) - 1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   page_addr;
      logic [REF_W-1:0]    ref_count;
      logic                released;
   } page_outcome_type;

   // Shadow copy of the allocator state.
   logic [PAGE_W-1:0]     free_pages [PAGES];
   logic [PAGE_W:0]       free_depth;
   logic [REF_W-1:0]      page_refs [PAGES];
   logic [REG_W-1:0]      low_bound;
   logic [REG_W-1:0]      top_bound;
   page_outcome_type      outcomes_due [$];

   // With 28-bit addresses and the default page count every page number is in range,
   // so the out-of-range page check can never fire and is not modeled.
   function automatic page_outcome_type predict_outcome(input logic [OP_W-1:0] op,
                                                        input logic [ADDR_W-1:0] pa);
      page_outcome_type  res;
      logic [PAGE_W-1:0] pg;
      logic [REF_W-1:0]  cnt;
      res = '0;
      res.status = ST_OK;
      pg = pa[ADDR_W-1:SHIFT];
      cnt = page_refs[pg];
      if (op == OP_ALLOC) begin
         if (free_depth == 0) begin
            res.status = ST_OOM;
         end else begin
            free_depth = free_depth - 1'b1;
            pg = free_pages[free_depth];
            page_refs[pg] = REF_W'(1);
            res.page_addr = {pg, {SHIFT{1'b0}}};
            res.ref_count = REF_W'(1);
         end
      end else if (op == OP_FREE) begin
         if (pa[SHIFT-1:0] != 0 || {1'b0, pa} < low_bound || {1'b0, pa} >= top_bound) begin
            res.status = ST_BAD;
         end else begin
            if (cnt != 0) cnt = cnt - 1'b1;
            page_refs[pg] = cnt;
            if (cnt != 0) begin
               res.ref_count = cnt;
            end else if (free_depth >= PAGES) begin
               // The count is still written back, but the page cannot go back on the stack.
               res.status = ST_OVF;
            end else begin
               free_pages[free_depth] = pg;
               free_depth = free_depth + 1'b1;
               res.released = 1'b1;
            end
         end
      end else begin
         if (op == OP_ADDREF && cnt != COUNT_TOP) cnt = cnt + 1'b1;
         page_refs[pg] = cnt;
         res.ref_count = cnt;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      failures++;
      if (failures <= 40)
         $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      page_outcome_type due;
      if (reset) begin
         free_depth = '0;
         low_bound = LOW_ADDR_RESET;
         top_bound = TOP_ADDR_RESET;
         foreach (page_refs[i]) page_refs[i] = '0;
         outcomes_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_LOW_ADDR) low_bound = csr_pwdata[REG_W-1:0];
               else top_bound = csr_pwdata[REG_W-1:0];
            end else if (csr_paddr[2] == REG_LOW_ADDR) begin
               if (csr_prdata[REG_W-1:0] != low_bound)
                  report_mismatch("low_addr read", csr_prdata, 32'(low_bound));
            end else if (csr_prdata[REG_W-1:0] != top_bound) begin
               report_mismatch("top_addr read", csr_prdata, 32'(top_bound));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (outcomes_due.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], 0);
            end else begin
               due = outcomes_due.pop_front();
               if (rsp_tdata[STATUS_W-1:0] != due.status)
                  report_mismatch("status", 32'(rsp_tdata[STATUS_W-1:0]), 32'(due.status));
               if (rsp_tdata[STATUS_W +: ADDR_W] != due.page_addr)
                  report_mismatch("page_addr", 32'(rsp_tdata[STATUS_W +: ADDR_W]),
                                  32'(due.page_addr));
               if (rsp_tdata[STATUS_W+ADDR_W +: REF_W] != due.ref_count)
                  report_mismatch("ref_count", 32'(rsp_tdata[STATUS_W+ADDR_W +: REF_W]),
                                  32'(due.ref_count));
               if (rsp_tdata[STATUS_W+ADDR_W+REF_W] != due.released)
                  report_mismatch("page_released", 32'(rsp_tdata[STATUS_W+ADDR_W+REF_W]),
                                  32'(due.released));
            end
         end
         if (req_tvalid && req_tready)
            outcomes_due.push_back(predict_outcome(req_tdata[OP_W-1:0],
                                                   req_tdata[OP_W +: ADDR_W]));
      end
      pending = outcomes_due.size();
   end

endmodule

// ===== verif/testbench.sv =====
module testbench import rpa_pkg::*;;

   // The watchdog must outlast the count-memory sweep after reset, which keeps
   // req_tready low until every entry is cleared, so the limit is several sweeps long.
   localparam int QUIET_LIMIT       = 300000;
   localparam int HOLD_CYCLES       = 200;
   localparam int RANDOM_PER_WINDOW = 400;
   localparam int SHIFT             = PAGE_SHIFT_DEFAULT;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int failures;
   int pending;
   int quiet_cycles = 0;
   int sent = 0;
   int windows = 0;

   // Shared pacing controls: idling turns random gaps on both sides on or off, and
   // hold_req asks the receiver for one long stall, which it times on its own.
   bit idling = 1'b1;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;

   refcounted_page_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   page_allocator_checker check_unit (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // The watchdog counts cycles in which no transfer of any kind takes place.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("** refcounted_page_allocator: FAILED **");
      $finish;
   end

   // The receiver changes rsp_tready only at falling edges. When the long stall is
   // requested it holds tready low for the HOLD_CYCLES stall while the sender keeps
   // offering requests, so the output register and the held-back request fill up.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= !(idling && $urandom_range(0, 99) < 34);
         end
      end
   end

   // Offers one request and returns at the falling edge after its transfer. Every
   // task here is entered at a falling edge where no assignment has been made yet,
   // so tvalid stays high between back-to-back requests without a glitch.
   task automatic send_req(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] pa);
      while (idling && $urandom_range(0, 99) < 34) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_W-OP_W-ADDR_W){1'b0}}, pa, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   // Stops offering and waits until every result has been checked, then keeps waiting
   // so that the block is idle before a register write.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One register access: a setup cycle, then an access cycle that completes at the
   // rising edge where pready is high.
   task automatic csr_access(input logic wr, input logic idx, input logic [REG_W-1:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {{(CSR_DW-REG_W){1'b0}}, val};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Sets the freeable window and reads both bounds back for the checker.
   task automatic set_window(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
      csr_access(1'b1, REG_LOW_ADDR, lo);
      csr_access(1'b1, REG_TOP_ADDR, hi);
      csr_access(1'b0, REG_LOW_ADDR, '0);
      csr_access(1'b0, REG_TOP_ADDR, '0);
      windows++;
   endtask

   // Mostly aligned addresses of pages in and just around the window, some with a
   // random offset, and a share of fully random addresses so every bit toggles.
   function automatic logic [ADDR_W-1:0] pick_addr(input int base_page, input int span);
      int                r;
      logic [ADDR_W-SHIFT-1:0] pg;
      logic [SHIFT-1:0]  off;
      r = $urandom_range(0, 99);
      if (r < 15) return ADDR_W'($urandom);
      pg = (ADDR_W-SHIFT)'(base_page - 2 + $urandom_range(0, span + 3));
      off = (r < 25) ? SHIFT'($urandom) : '0;
      return {pg, off};
   endfunction

   initial begin
      int                lo_page;
      int                span;
      int                r;
      logic [REG_W-1:0]  lo;
      logic [REG_W-1:0]  hi;
      logic [OP_W-1:0]   op;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full address range. Requests wait out the count sweep after reset.
      set_window(29'h0, 29'h1000_0000);
      send_req(OP_ALLOC, 28'h0);            // empty stack: out of memory
      send_req(OP_QUERY, 28'h0);
      send_req(OP_QUERY, 28'hFFF_FFFF);     // offset bits are dropped
      send_req(OP_FREE, 28'h000_0000);      // count already zero: pushed during set-up
      send_req(OP_FREE, 28'hFFF_F000);      // highest page
      send_req(OP_FREE, 28'h000_1001);      // misaligned
      send_req(OP_FREE, 28'h000_1800);      // misaligned
      send_req(OP_ADDREF, 28'hFFF_F123);
      send_req(OP_ALLOC, 28'hFFF_FFFF);     // last in, first out: highest page
      send_req(OP_ADDREF, 28'hFFF_F000);
      send_req(OP_FREE, 28'hFFF_F000);      // count drops but stays above zero
      send_req(OP_FREE, 28'hFFF_F000);      // count reaches zero: page released
      send_req(OP_ALLOC, 28'h0);
      send_req(OP_ALLOC, 28'h0);
      send_req(OP_ALLOC, 28'h0);            // stack drained again
      drain_results();

      // Narrow window: frees just below and at the top bound are rejected.
      set_window(29'h000_2000, 29'h000_8000);
      send_req(OP_FREE, 28'h000_1000);
      send_req(OP_FREE, 28'h000_8000);
      send_req(OP_FREE, 28'h000_7000);
      send_req(OP_FREE, 28'h000_2000);
      drain_results();

      // Inverted extremes: no address can be freed at all.
      set_window(29'h1000_0000, 29'h0);
      send_req(OP_FREE, 28'h000_0000);
      send_req(OP_FREE, 28'hFFF_F000);
      send_req(OP_QUERY, 28'h000_7000);

      // Raise one count well past its ceiling to check that it saturates.
      repeat (260) send_req(OP_ADDREF, {16'h0003, 12'($urandom)});
      send_req(OP_QUERY, 28'h000_3000);
      drain_results();

      // Random windows. Each starts the way software does, by freeing every page in
      // the window once, and then runs a random mix of operations in and around it.
      for (int phase = 0; phase < 3; phase++) begin
         lo_page = $urandom_range(2, 16'hFF00);
         span = $urandom_range(16, 96);
         lo = REG_W'(lo_page << SHIFT);
         hi = REG_W'((lo_page + span) << SHIFT);
         // The last window has an unaligned lower bound, so its first page is out.
         if (phase == 2) lo = lo + REG_W'($urandom_range(1, 4095));
         set_window(lo, hi);
         if (phase == 0) hold_req = 1'b1;
         if (phase == 1) idling = 1'b0;
         for (int pg = lo_page; pg < lo_page + span; pg++)
            send_req(OP_FREE, ADDR_W'(pg << SHIFT));
         for (int n = 0; n < RANDOM_PER_WINDOW; n++) begin
            if (n == 250) idling = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 30) op = OP_ALLOC;
            else if (r < 60) op = OP_FREE;
            else if (r < 80) op = OP_ADDREF;
            else op = OP_QUERY;
            send_req(op, pick_addr(lo_page, span));
         end
         drain_results();
      end

      // Back to the full window: take a few pages from the stack and release one more.
      set_window(29'h0, 29'h1000_0000);
      repeat (4) send_req(OP_ALLOC, ADDR_W'($urandom));
      send_req(OP_FREE, 28'hFFF_E000);
      send_req(OP_QUERY, 28'hFFF_E000);
      drain_results();
      repeat (10) @(negedge clock);

      $display("Checked %0d requests over %0d address windows, with a %0d-cycle receiver stall,",
               sent, windows, HOLD_CYCLES);
      $display("count saturation, rejected frees and last-in first-out reuse of pages.");
      if (failures == 0) begin
         $display("** refcounted_page_allocator: PASSED **");
      end else begin
         $display("** refcounted_page_allocator: FAILED **");
      end
      $finish;
   end

endmodule
